FILE: rtl/mat4_vector_transform_defines.svh
// assertion macros for the transform engine
`ifndef MAT4_VECTOR_TRANSFORM_DEFINES_SVH
`define MAT4_VECTOR_TRANSFORM_DEFINES_SVH

// same-cycle implication, reset disables
`define MVT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset disables
`define MVT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mvt_pkg.sv
// types, constants and float helper functions of the transform engine
package mvt_pkg;

  localparam int unsigned NumRegs = 8;
  localparam logic [31:0] QNan    = 32'h7FC0_0000;
  localparam logic [30:0] Inf31   = 31'h7F80_0000;

  localparam logic [63:0] MatReset [NumRegs] = '{
    64'h0000_0000_3F80_0000, 64'h0, 64'h3F80_0000_0000_0000, 64'h0,
    64'h0, 64'h0000_0000_3F80_0000, 64'h0, 64'h3F80_0000_0000_0000
  };

  // unrounded value or finished special result
  typedef struct packed {
    logic               spec;
    logic [31:0]        bits;
    logic               sign;
    logic signed [11:0] e;
    logic [63:0]        sig;
  } unr_t;

  // value with rounding position worked out
  typedef struct packed {
    logic               spec;
    logic [31:0]        bits;
    logic               sign;
    logic               inf;
    logic               norm;
    logic [7:0]         be_m1;
    logic signed [11:0] sh;
    logic [63:0]        sig;
  } nrm_t;

  function automatic logic f_isnan(logic [31:0] x);
    return x[30:0] > Inf31;
  endfunction

  function automatic logic f_isinf(logic [31:0] x);
    return x[30:0] == Inf31;
  endfunction

  function automatic logic f_iszero(logic [31:0] x);
    return x[30:0] == 31'd0;
  endfunction

  function automatic logic [23:0] f_sig(logic [31:0] x);
    return {|x[30:23], x[22:0]};
  endfunction

  function automatic logic signed [11:0] f_exp(logic [31:0] x);
    return (x[30:23] == 8'd0) ? 12'sd1 : $signed({4'b0, x[30:23]});
  endfunction

  function automatic unr_t fmul_pre(logic [31:0] a, logic [31:0] b);
    unr_t        r;
    logic        s;
    logic [47:0] p;
    r      = '0;
    s      = a[31] ^ b[31];
    r.sign = s;
    p      = 48'(f_sig(a)) * 48'(f_sig(b));
    if (f_isnan(a) || f_isnan(b)) begin
      r.spec = 1'b1;
      r.bits = QNan;
    end else if (f_isinf(a) || f_isinf(b)) begin
      r.spec = 1'b1;
      r.bits = (f_iszero(a) || f_iszero(b)) ? QNan : {s, Inf31};
    end else if (f_iszero(a) || f_iszero(b)) begin
      r.spec = 1'b1;
      r.bits = {s, 31'd0};
    end else begin
      r.e   = f_exp(a) + f_exp(b) - 12'sd300;
      r.sig = {16'd0, p};
    end
    return r;
  endfunction

  function automatic unr_t fadd_pre(logic [31:0] a, logic [31:0] b);
    unr_t               r;
    logic               sa, sb, ts, lost;
    logic signed [11:0] ex, ey, te, d;
    logic [63:0]        gx, gy, tg, sh, sum;
    r  = '0;
    sa = a[31];
    sb = b[31];
    ex = f_exp(a);
    ey = f_exp(b);
    gx = {40'd0, f_sig(a)} << 35;
    gy = {40'd0, f_sig(b)} << 35;
    if (ex < ey) begin
      tg = gx; gx = gy; gy = tg;
      te = ex; ex = ey; ey = te;
      ts = sa; sa = sb; sb = ts;
    end
    d = ex - ey;
    if (d >= 12'sd63) begin
      gy = {63'd0, |gy};
    end else if (d > 12'sd0) begin
      sh   = gy >> d[5:0];
      lost = (sh << d[5:0]) != gy;
      gy   = sh | {63'd0, lost};
    end
    if (sa == sb) begin
      sum    = gx + gy;
      r.sign = sa;
    end else if (gx >= gy) begin
      sum    = gx - gy;
      r.sign = sa;
    end else begin
      sum    = gy - gx;
      r.sign = sb;
    end
    r.e   = ex - 12'sd185;
    r.sig = sum;
    if (f_isnan(a) || f_isnan(b)) begin
      r.spec = 1'b1;
      r.bits = QNan;
    end else if (f_isinf(a) && f_isinf(b)) begin
      r.spec = 1'b1;
      r.bits = (a[31] == b[31]) ? a : QNan;
    end else if (f_isinf(a)) begin
      r.spec = 1'b1;
      r.bits = a;
    end else if (f_isinf(b)) begin
      r.spec = 1'b1;
      r.bits = b;
    end else if (f_iszero(a) && f_iszero(b)) begin
      r.spec = 1'b1;
      r.bits = {a[31] & b[31], 31'd0};
    end else if (f_iszero(a)) begin
      r.spec = 1'b1;
      r.bits = b;
    end else if (f_iszero(b)) begin
      r.spec = 1'b1;
      r.bits = a;
    end else if (sum == 64'd0) begin
      r.spec = 1'b1;
      r.bits = 32'd0;
    end
    return r;
  endfunction

  // leading one search and rounding position
  function automatic nrm_t rnd_pos(unr_t u);
    nrm_t               o;
    logic [6:0]         n;
    logic signed [11:0] big_e, be, lsb;
    n = 7'd0;
    for (int i = 0; i < 64; i++) begin
      if (u.sig[i]) n = 7'(i + 1);
    end
    big_e   = u.e + $signed({5'd0, n}) - 12'sd1;
    be      = big_e + 12'sd127;
    o.spec  = u.spec;
    o.bits  = u.bits;
    o.sign  = u.sign;
    o.sig   = u.sig;
    o.inf   = be >= 12'sd255;
    o.norm  = be >= 12'sd1;
    o.be_m1 = 8'(be - 12'sd1);
    lsb     = o.norm ? big_e - 12'sd23 : -12'sd149;
    o.sh    = lsb - u.e;
    return o;
  endfunction

  // shift, round to nearest even, pack
  function automatic logic [31:0] rnd_pack(nrm_t o);
    logic [63:0]        q, rem, half;
    logic [5:0]         amt;
    logic signed [11:0] nsh;
    logic [31:0]        b;
    nsh = -o.sh;
    amt = o.sh[5:0];
    q   = 64'd0;
    if (o.sh <= 12'sd0) begin
      q = o.sig << nsh[5:0];
    end else if (o.sh <= 12'sd60) begin
      q    = o.sig >> amt;
      rem  = o.sig & ((64'd1 << amt) - 64'd1);
      half = 64'd1 << (amt - 6'd1);
      if (rem > half || (rem == half && q[0])) q = q + 64'd1;
    end
    b = o.norm ? 32'({o.be_m1, 23'd0}) + q[31:0] : q[31:0];
    if (b >= {1'b0, Inf31}) b = {1'b0, Inf31};
    if (o.spec) return o.bits;
    if (o.inf) return {o.sign, Inf31};
    return {o.sign, b[30:0]};
  endfunction

endpackage

FILE: rtl/mat4_vector_transform.sv
// 4x4 single-precision matrix times column vector, nine-stage pipeline
// One item is accepted per clock unless the input is stalled. The stages are:
// sixteen 24x24 significand products, product leading-one search, product rounding,
// first add level (align and add), its leading-one search, its rounding, then the
// same three steps for the second add level. Each stage holds its own valid bit, so
// bubbles are squeezed out and input is stalled only when every stage is full and
// the output is stalled. The user must write the matrix through the configuration
// port only while no item is in flight (not enforced); it is identity after reset.
`include "mat4_vector_transform_defines.svh"
module mat4_vector_transform
  import mvt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] vec_x_i,
  input  logic [31:0] vec_y_i,
  input  logic [31:0] vec_z_i,
  input  logic [31:0] vec_w_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] out_x_o,
  output logic [31:0] out_y_o,
  output logic [31:0] out_z_o,
  output logic [31:0] out_w_o
);

  logic [63:0] m_q [NumRegs];
  logic [31:0] vin [4];
  logic [9:1]  v_q;
  logic [9:0]  vc;
  logic [10:1] en;

  unr_t        s1_q [16];
  nrm_t        s2_q [16];
  logic [31:0] s3_q [16];
  unr_t        s4_q [8];
  nrm_t        s5_q [8];
  logic [31:0] s6_q [8];
  unr_t        s7_q [4];
  nrm_t        s8_q [4];
  logic [31:0] s9_q [4];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NumRegs; r++) m_q[r] <= MatReset[r];
    end else if (cfg_valid_i && cfg_index_i < 8'(NumRegs)) begin
      m_q[cfg_index_i[2:0]] <= cfg_data_i;
    end
  end

  assign vin[0] = vec_x_i;
  assign vin[1] = vec_y_i;
  assign vin[2] = vec_z_i;
  assign vin[3] = vec_w_i;

  // stage k moves when empty or when stage k+1 moves
  always_comb begin
    en[10] = !out_stall_i;
    for (int k = 9; k >= 1; k--) en[k] = !v_q[k] || en[k+1];
  end

  assign vc         = {v_q, in_valid_i};
  assign in_stall_o = !en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 1; k <= 9; k++) begin
        if (en[k]) v_q[k] <= vc[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      for (int i = 0; i < 4; i++) begin
        for (int k = 0; k < 4; k++) begin
          s1_q[i*4+k] <= fmul_pre(m_q[k*2 + i/2][(i%2)*32 +: 32], vin[k]);
        end
      end
    end
    if (en[2]) begin
      for (int p = 0; p < 16; p++) s2_q[p] <= rnd_pos(s1_q[p]);
    end
    if (en[3]) begin
      for (int p = 0; p < 16; p++) s3_q[p] <= rnd_pack(s2_q[p]);
    end
    if (en[4]) begin
      for (int p = 0; p < 8; p++) s4_q[p] <= fadd_pre(s3_q[2*p], s3_q[2*p+1]);
    end
    if (en[5]) begin
      for (int p = 0; p < 8; p++) s5_q[p] <= rnd_pos(s4_q[p]);
    end
    if (en[6]) begin
      for (int p = 0; p < 8; p++) s6_q[p] <= rnd_pack(s5_q[p]);
    end
    if (en[7]) begin
      for (int p = 0; p < 4; p++) s7_q[p] <= fadd_pre(s6_q[2*p], s6_q[2*p+1]);
    end
    if (en[8]) begin
      for (int p = 0; p < 4; p++) s8_q[p] <= rnd_pos(s7_q[p]);
    end
    if (en[9]) begin
      for (int p = 0; p < 4; p++) s9_q[p] <= rnd_pack(s8_q[p]);
    end
  end

  assign out_valid_o = v_q[9];
  assign out_x_o     = s9_q[0];
  assign out_y_o     = s9_q[1];
  assign out_z_o     = s9_q[2];
  assign out_w_o     = s9_q[3];

  `MVT_ASSERT_NOW(a_stall_full, in_stall_o, (&v_q) && out_stall_i, "stall with room in pipe")
  `MVT_ASSERT_NEXT(a_out_kept, out_valid_o && out_stall_i, out_valid_o, "stalled item lost")
  `MVT_ASSERT_NEXT(a_in_taken, in_valid_i && !in_stall_o, v_q[1], "accepted item dropped")

endmodule

FILE: tb/sv/mat4_vector_transform_tb.sv
// testbench for the 4x4 float matrix-vector transform engine
module mat4_vector_transform_tb
  import mvt_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxQuiet  = 20000;
  localparam int DrainWait = 40;
  localparam logic [7:0] RegCol0Lo = 8'd0;
  localparam logic [7:0] RegCol3Hi = 8'd7;
  localparam logic [7:0] RegBad    = 8'd9;
  localparam logic [31:0] PosZero = 32'h0000_0000;
  localparam logic [31:0] NegZero = 32'h8000_0000;
  localparam logic [31:0] PosInf  = 32'h7F80_0000;
  localparam logic [31:0] NegInf  = 32'hFF80_0000;
  localparam logic [31:0] SNan    = 32'h7F80_0001;
  localparam logic [31:0] MaxNorm = 32'h7F7F_FFFF;
  localparam logic [31:0] MinSub  = 32'h0000_0001;
  localparam logic [31:0] MaxSub  = 32'h007F_FFFF;
  localparam logic [31:0] One     = 32'h3F80_0000;

  typedef struct packed {
    logic [31:0] x, y, z, w;
  } vec4_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] vec_x_i = '0, vec_y_i = '0, vec_z_i = '0, vec_w_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [31:0] out_x_o, out_y_o, out_z_o, out_w_o;

  logic [63:0] mat_regs [NumRegs];
  vec4_t       expected_q [$];
  int          mismatches = 0;
  int          quiet_cycles = 0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          hold_cycles = 0;

  mat4_vector_transform u_top (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // ieee binary32 arithmetic, round to nearest even
  function automatic logic is_nan(logic [31:0] a);
    return a[30:0] > 31'h7F80_0000;
  endfunction

  function automatic logic is_inf(logic [31:0] a);
    return a[30:0] == 31'h7F80_0000;
  endfunction

  function automatic logic is_zero(logic [31:0] a);
    return a[30:0] == 31'd0;
  endfunction

  function automatic logic [63:0] mant(logic [31:0] a);
    return {40'd0, a[30:23] != 0, a[22:0]};
  endfunction

  function automatic int expo(logic [31:0] a);
    return (a[30:23] == 0) ? 1 : int'(a[30:23]);
  endfunction

  function automatic logic [31:0] round_to_single(logic sgn, int e, logic [63:0] m);
    int          width, top_e, biased, lsb_pos, sh;
    logic [63:0] q, rem, half;
    logic [31:0] packed_bits;
    if (m == 0) return {sgn, 31'd0};
    width = 0;
    for (int i = 0; i < 64; i++) if (m[i]) width = i + 1;
    top_e = e + width - 1;
    biased = top_e + 127;
    if (biased >= 255) return {sgn, 31'h7F80_0000};
    lsb_pos = (biased >= 1) ? top_e - 23 : -149;
    sh = lsb_pos - e;
    if (sh <= 0) q = m << (-sh);
    else if (sh > 60) q = 0;
    else begin
      q = m >> sh;
      rem = m & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q = q + 1;
    end
    packed_bits = (biased >= 1) ? (32'(biased - 1) << 23) + q[31:0] : q[31:0];
    if (packed_bits >= 32'h7F80_0000) packed_bits = 32'h7F80_0000;
    return {sgn, packed_bits[30:0]};
  endfunction

  function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
    logic sgn;
    sgn = a[31] ^ b[31];
    if (is_nan(a) || is_nan(b)) return QNan;
    if (is_inf(a) || is_inf(b))
      return (is_zero(a) || is_zero(b)) ? QNan : {sgn, 31'h7F80_0000};
    if (is_zero(a) || is_zero(b)) return {sgn, 31'd0};
    return round_to_single(sgn, expo(a) + expo(b) - 300, mant(a) * mant(b));
  endfunction

  function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
    logic        sa, sb, sr, ts;
    logic [63:0] ga, gb, tg, r;
    int          ea, eb, te, d;
    if (is_nan(a) || is_nan(b)) return QNan;
    if (is_inf(a) && is_inf(b)) return (a[31] == b[31]) ? a : QNan;
    if (is_inf(a)) return a;
    if (is_inf(b)) return b;
    if (is_zero(a) && is_zero(b)) return {a[31] & b[31], 31'd0};
    if (is_zero(a)) return b;
    if (is_zero(b)) return a;
    sa = a[31]; sb = b[31];
    ea = expo(a); eb = expo(b);
    ga = mant(a) << 35; gb = mant(b) << 35;
    if (ea < eb) begin
      tg = ga; ga = gb; gb = tg;
      te = ea; ea = eb; eb = te;
      ts = sa; sa = sb; sb = ts;
    end
    d = ea - eb;
    if (d >= 63) gb = 64'(gb != 0);
    else if (d > 0) gb = (gb >> d) | 64'((gb & ((64'd1 << d) - 1)) != 0);
    if (sa == sb) begin
      r = ga + gb; sr = sa;
    end else if (ga >= gb) begin
      r = ga - gb; sr = sa;
    end else begin
      r = gb - ga; sr = sb;
    end
    if (r == 0) return 32'd0;
    return round_to_single(sr, ea - 185, r);
  endfunction

  function automatic logic [31:0] mat_elem(int row, int col);
    logic [63:0] r;
    r = mat_regs[col * 2 + row / 2];
    return (row % 2) ? r[63:32] : r[31:0];
  endfunction

  function automatic vec4_t transform(vec4_t v);
    logic [31:0] vin [4];
    logic [31:0] res [4];
    logic [31:0] p [4];
    vin = '{v.x, v.y, v.z, v.w};
    for (int i = 0; i < 4; i++) begin
      for (int k = 0; k < 4; k++) p[k] = fp_mul(mat_elem(i, k), vin[k]);
      res[i] = fp_add(fp_add(p[0], p[1]), fp_add(p[2], p[3]));
    end
    return '{res[0], res[1], res[2], res[3]};
  endfunction

  function automatic logic [31:0] rand_float();
    case ($urandom_range(0, 9))
      0: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'd0, 23'($urandom)};
      1: return {$urandom_range(0, 1) ? 1'b1 : 1'b0, 8'hFF, 23'($urandom_range(0, 3))};
      2: return $urandom_range(0, 1) ? PosZero : NegZero;
      3: return $urandom;
      default: return {$urandom_range(0, 1) ? 1'b1 : 1'b0,
                       8'($urandom_range(110, 144)), 23'($urandom)};
    endcase
  endfunction

  task automatic write_reg(logic [7:0] idx, logic [63:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx < NumRegs) mat_regs[idx[2:0]] = data;
  endtask

  task automatic send_vec(vec4_t v);
    cfg_valid_i <= 1'b0;
    while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    {vec_x_i, vec_y_i, vec_z_i, vec_w_i} <= v;
    do @(posedge clk_i); while (in_stall_o);
    expected_q.push_back(transform(v));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() > 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  task automatic load_random_matrix(logic bounded);
    for (int r = 0; r < NumRegs; r++)
      if (bounded)
        write_reg(8'(r), {1'b0, 8'($urandom_range(120, 132)), 23'($urandom),
                          1'b1, 8'($urandom_range(120, 132)), 23'($urandom)});
      else write_reg(8'(r), {rand_float(), rand_float()});
  endtask

  task automatic test_identity_specials();
    send_vec('{One, NegZero, PosInf, QNan});
    send_vec('{MaxNorm, MaxNorm, MinSub, MaxSub});
    send_vec('{NegInf, SNan, PosZero, 32'hFFFF_FFFF});
    send_vec('{32'h0, 32'h0, 32'h0, 32'h0});
    send_vec('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
  endtask

  task automatic test_directed_matrix();
    drain();
    for (int r = 0; r < NumRegs; r++) write_reg(8'(r), {MaxNorm, MaxNorm});
    send_vec('{MaxNorm, MaxNorm, MaxNorm, MaxNorm});
    send_vec('{32'hFF7F_FFFF, MaxNorm, 32'hFF7F_FFFF, MaxNorm});
    send_vec('{PosZero, PosInf, NegInf, One});
    send_vec('{MinSub, MinSub, MinSub, MinSub});
    drain();
    for (int r = 0; r < NumRegs; r++) write_reg(8'(r), {NegZero, NegZero});
    send_vec('{One, One, One, One});
    send_vec('{NegZero, PosZero, MaxSub, NegInf});
    drain();
    for (int r = 0; r < NumRegs; r++) write_reg(8'(r), {MinSub, 32'h3F00_0000});
    send_vec('{32'h3F00_0000, MaxSub, 32'hBF00_0000, MinSub});
    send_vec('{One, 32'hBF80_0000, One, 32'hBF80_0000});
    drain();
    write_reg(RegBad, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(RegCol0Lo, 64'h0);
    write_reg(RegCol3Hi, 64'hFFFF_FFFF_FFFF_FFFF);
    send_vec('{One, One, One, One});
  endtask

  task automatic test_random_stream(int n, int sidle, int ridle, logic bounded);
    drain();
    load_random_matrix(bounded);
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    for (int i = 0; i < n; i++) send_vec('{rand_float(), rand_float(), rand_float(), rand_float()});
  endtask

  task automatic test_backpressure();
    hold_cycles = 60;
    send_idle_pct = 0;
    for (int i = 0; i < 30; i++) send_vec('{rand_float(), rand_float(), rand_float(), rand_float()});
  endtask

  always @(posedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall_i <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall_i <= (recv_idle_pct > 0) && ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    vec4_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h %h %h %h",
                                       out_x_o, out_y_o, out_z_o, out_w_o);
      end else begin
        want = expected_q.pop_front();
        if (want != {out_x_o, out_y_o, out_z_o, out_w_o}) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %h %h %h %h got %h %h %h %h", want.x, want.y, want.z,
                     want.w, out_x_o, out_y_o, out_z_o, out_w_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= MaxQuiet) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    for (int r = 0; r < NumRegs; r++) mat_regs[r] = MatReset[r];
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_identity_specials();
    test_directed_matrix();
    test_random_stream(480, 24, 48, 1'b1);
    test_random_stream(470, 48, 24, 1'b0);
    test_backpressure();
    test_random_stream(450, 0, 0, 1'b1);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain();
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
